// File: hdl/rdib_pkg.sv
// rdib_pkg: shared constants, tables and types for the run-level dequant idct block decoder
// used by rdib_idct_line, rle_dequant_idct_block_decoder_core and rdib_checker
package rdib_pkg;

  localparam int unsigned BLOCK_DIM     = 8;
  localparam int unsigned BLOCKS_PER_MB = 6;

  localparam logic [15:0] END_CODE = 16'hFE00;

  localparam logic [1:0] REQ_RUN    = 2'd0;
  localparam logic [1:0] REQ_LUMA   = 2'd1;
  localparam logic [1:0] REQ_CHROMA = 2'd2;

  localparam logic [31:0] K_B6 = 32'((64'd18159528 + 64'd2048) >> 12);
  localparam logic [31:0] K_A4 = 32'((64'd23726566 + 64'd2048) >> 12);
  localparam logic [31:0] K_A2 = 32'((64'd31000253 + 64'd2048) >> 12);
  localparam logic [31:0] K_B2 = 32'((64'd43840978 + 64'd2048) >> 12);

  localparam logic [20:0] PRESCALE_NAT [64] = '{
    21'd1048576, 21'd1454417, 21'd1370031, 21'd1232995,
    21'd1048576, 21'd823861,  21'd567485,  21'd289301,
    21'd1454417, 21'd2017334, 21'd1900287, 21'd1710213,
    21'd1454417, 21'd1142728, 21'd787125,  21'd401273,
    21'd1370031, 21'd1900287, 21'd1790031, 21'd1610986,
    21'd1370031, 21'd1076426, 21'd741455,  21'd377991,
    21'd1232995, 21'd1710213, 21'd1610986, 21'd1449849,
    21'd1232995, 21'd968758,  21'd667292,  21'd340183,
    21'd1048576, 21'd1454417, 21'd1370031, 21'd1232995,
    21'd1048576, 21'd823861,  21'd567485,  21'd289301,
    21'd823861,  21'd1142728, 21'd1076426, 21'd968758,
    21'd823861,  21'd647303,  21'd445870,  21'd227303,
    21'd567485,  21'd787125,  21'd741455,  21'd667292,
    21'd567485,  21'd445870,  21'd307121,  21'd156569,
    21'd289301,  21'd401273,  21'd377991,  21'd340183,
    21'd289301,  21'd227303,  21'd156569,  21'd79818
  };

  localparam logic [5:0] ZZ_TO_NAT [64] = '{
    6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_WR,
    ST_LD,
    ST_START,
    ST_CALC,
    ST_ST,
    ST_OUT
  } state_e;

  typedef logic [7:0][31:0] line_t;

  // rounded prescale for a zigzag index
  function automatic logic [16:0] prescale(input logic [5:0] idx);
    logic [21:0] p;
    p = 22'(PRESCALE_NAT[ZZ_TO_NAT[idx]]) + 22'd8;
    return p[20:4];
  endfunction

  function automatic logic [31:0] asr12(input logic [31:0] x);
    return 32'($signed(x) >>> 12);
  endfunction

endpackage

// File: hdl/rdib_idct_line.sv
// rdib_idct_line: pipelined 8-point aan inverse dct over one row or column
// depends on rdib_pkg for the multiplier constants
module rdib_idct_line (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_en_i,
  input  logic [2:0]          load_idx_i,
  input  logic [31:0]         load_data_i,
  input  logic                start_i,
  output logic                done_o,
  output rdib_pkg::line_t     res_o
);

  rdib_pkg::line_t a_q;
  logic [4:0] v_q;

  logic [31:0] e_z10_q, e_z11_q, e_z13_q, e_d26_q;
  logic [31:0] o_z13_q, o_z10_q, o_z11_q, o_z12_q;
  logic [31:0] s2_z10_q, s2_z11_q, s2_z13_q, m_e_q, m_a2_q, m_b2_q, m_o_q, m_b6_q, s2_t7_q;
  logic [31:0] s3_t0_q, s3_t3_q, s3_z11_q, s3_z12_q, s3_t7_q, s3_t6_q, s3_x5_q, s3_x4_q;
  logic [31:0] s4_t0_q, s4_t3_q, s4_t7_q, s4_t6_q, s4_t1_q, s4_t2_q, s4_t5_q, s4_t4_q;
  logic [31:0] t5, t6;

  assign t6 = rdib_pkg::asr12(m_b2_q + m_a2_q) - s2_t7_q;
  assign t5 = s3_x5_q - s3_t6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      a_q[load_idx_i] <= load_data_i;
    end
    // sums
    e_z10_q <= a_q[0] + a_q[4];
    e_z11_q <= a_q[0] - a_q[4];
    e_z13_q <= a_q[2] + a_q[6];
    e_d26_q <= a_q[2] - a_q[6];
    o_z13_q <= a_q[3] + a_q[5];
    o_z10_q <= a_q[3] - a_q[5];
    o_z11_q <= a_q[1] + a_q[7];
    o_z12_q <= a_q[1] - a_q[7];
    // products
    s2_z10_q <= e_z10_q;
    s2_z11_q <= e_z11_q;
    s2_z13_q <= e_z13_q;
    m_e_q    <= e_d26_q * rdib_pkg::K_A4;
    m_a2_q   <= (o_z12_q - o_z10_q) * rdib_pkg::K_A2;
    m_b2_q   <= o_z10_q * rdib_pkg::K_B2;
    m_o_q    <= (o_z11_q - o_z13_q) * rdib_pkg::K_A4;
    m_b6_q   <= o_z12_q * rdib_pkg::K_B6;
    s2_t7_q  <= o_z11_q + o_z13_q;
    // scaling
    s3_t0_q  <= s2_z10_q + s2_z13_q;
    s3_t3_q  <= s2_z10_q - s2_z13_q;
    s3_z11_q <= s2_z11_q;
    s3_z12_q <= rdib_pkg::asr12(m_e_q) - s2_z13_q;
    s3_t7_q  <= s2_t7_q;
    s3_t6_q  <= t6;
    s3_x5_q  <= rdib_pkg::asr12(m_o_q);
    s3_x4_q  <= rdib_pkg::asr12(m_b6_q - m_a2_q);
    // odd chain
    s4_t0_q  <= s3_t0_q;
    s4_t3_q  <= s3_t3_q;
    s4_t7_q  <= s3_t7_q;
    s4_t6_q  <= s3_t6_q;
    s4_t1_q  <= s3_z11_q + s3_z12_q;
    s4_t2_q  <= s3_z11_q - s3_z12_q;
    s4_t5_q  <= t5;
    s4_t4_q  <= s3_x4_q + t5;
    // butterflies
    if (v_q[3]) begin
      res_o[0] <= s4_t0_q + s4_t7_q;
      res_o[7] <= s4_t0_q - s4_t7_q;
      res_o[1] <= s4_t1_q + s4_t6_q;
      res_o[6] <= s4_t1_q - s4_t6_q;
      res_o[2] <= s4_t2_q + s4_t5_q;
      res_o[5] <= s4_t2_q - s4_t5_q;
      res_o[4] <= s4_t3_q + s4_t4_q;
      res_o[3] <= s4_t3_q - s4_t4_q;
    end
  end

  assign done_o = v_q[4];

endmodule

// File: hdl/rle_dequant_idct_block_decoder_core.sv
// rle_dequant_idct_block_decoder_core: top level, quant and coefficient memories, control
// depends on rdib_pkg and rdib_idct_line
//
//   channel  | direction | handshake                | payload
//   in       | input     | in_valid_i / in_ready_o  | req_type_i, table_index_i, word_value_i
//   out      | output    | out_valid_o / out_ready_i| block_number_o, pixel_position_o,
//            |           |                          | sample_out_o, block_last_o, macroblock_last_o
//
// a quant byte or ignored request is taken in idle; dc goes mul1, wr; ac mul1, mul2, wr
// a block end runs 8 column and 8 row lines through the single coefficient memory port:
// column lines are loaded, computed and stored, row lines loaded, computed and sent out
// the idct runs sequentially and no input is taken until the 64th sample transfer
// out_ready_i low holds the current sample and stops the row pass
// reset clears control state and the coefficient valid bits; no clearing pass
module rle_dequant_idct_block_decoder_core #(
  parameter int unsigned BLOCKS_PER_MB = rdib_pkg::BLOCKS_PER_MB
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [5:0]  table_index_i,
  input  logic [15:0] word_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  block_number_o,
  output logic [5:0]  pixel_position_o,
  output logic [31:0] sample_out_o,
  output logic        block_last_o,
  output logic        macroblock_last_o
);

  rdib_pkg::state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [2:0] line_q, line_d;
  logic       pass_q, pass_d;

  logic [2:0]  blk_q;
  logic [5:0]  pos_q, scale_q;
  logic        expect_dc_q, dc_q;
  logic [9:0]  val_q;
  logic [31:0] prod_q;

  logic [24:0] qmem [128];
  logic [24:0] q_rdata_q;
  logic        q_we;
  logic [6:0]  q_waddr, q_raddr;
  logic [24:0] q_wdata;

  logic [31:0] cmem [64];
  logic [63:0] cvalid_q;
  logic [31:0] c_rdata_q;
  logic        c_rvld_q;
  logic        c_we, c_clr;
  logic [5:0]  c_addr;
  logic [31:0] c_wdata;

  logic        ld_pend_q;
  logic [2:0]  ld_idx_q;
  logic        line_start, line_done;
  rdib_pkg::line_t line_res;

  logic        in_fire, out_fire, run_fire, blk_end;
  logic [6:0]  new_pos;
  logic [31:0] sx_val, rnd_val;
  logic        last_out;

  assign in_ready_o  = (state_q == rdib_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign run_fire    = in_fire && (req_type_i == rdib_pkg::REQ_RUN);
  assign out_valid_o = (state_q == rdib_pkg::ST_OUT);
  assign out_fire    = out_valid_o && out_ready_i;
  assign new_pos     = {1'b0, pos_q} + {1'b0, word_value_i[15:10]} + 7'd1;
  assign blk_end     = !expect_dc_q && ((word_value_i == rdib_pkg::END_CODE) || new_pos[6]);
  assign last_out    = (line_q == 3'd7) && (cnt_q[2:0] == 3'd7);

  // quant memory
  assign q_we    = in_fire && ((req_type_i == rdib_pkg::REQ_LUMA) ||
                               (req_type_i == rdib_pkg::REQ_CHROMA));
  assign q_waddr = {req_type_i == rdib_pkg::REQ_CHROMA, table_index_i};
  assign q_wdata = 25'(word_value_i[7:0]) * 25'(rdib_pkg::prescale(table_index_i));
  assign q_raddr = {blk_q < 3'd2, expect_dc_q ? 6'd0 : new_pos[5:0]};

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      qmem[q_waddr] <= q_wdata;
    end
    q_rdata_q <= qmem[q_raddr];
  end

  // coefficient memory
  assign sx_val  = {{22{val_q[9]}}, val_q};
  assign rnd_val = dc_q ? 32'($signed(prod_q + 32'd256) >>> 9)
                        : 32'($signed(prod_q + 32'd2048) >>> 12);

  always_comb begin
    c_we    = 1'b0;
    c_clr   = 1'b0;
    c_addr  = {cnt_q[2:0], line_q};
    c_wdata = rnd_val;
    case (state_q)
      rdib_pkg::ST_WR: begin
        c_we   = 1'b1;
        c_addr = dc_q ? 6'd0 : rdib_pkg::ZZ_TO_NAT[pos_q];
      end
      rdib_pkg::ST_LD: begin
        c_addr = pass_q ? {line_q, cnt_q[2:0]} : {cnt_q[2:0], line_q};
        c_clr  = pass_q && !cnt_q[3];
      end
      rdib_pkg::ST_ST: begin
        c_we    = 1'b1;
        c_wdata = line_res[cnt_q[2:0]];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      cmem[c_addr] <= c_wdata;
    end
    c_rdata_q <= cmem[c_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvalid_q  <= '0;
      c_rvld_q  <= 1'b0;
      ld_pend_q <= 1'b0;
      ld_idx_q  <= '0;
    end else begin
      c_rvld_q <= cvalid_q[c_addr];
      if (c_we) begin
        cvalid_q[c_addr] <= 1'b1;
      end else if (c_clr) begin
        cvalid_q[c_addr] <= 1'b0;
      end
      ld_pend_q <= (state_q == rdib_pkg::ST_LD) && !cnt_q[3];
      ld_idx_q  <= cnt_q[2:0];
    end
  end

  assign line_start = (state_q == rdib_pkg::ST_START);

  rdib_idct_line u_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_en_i   (ld_pend_q),
    .load_idx_i  (ld_idx_q),
    .load_data_i (c_rvld_q ? c_rdata_q : 32'd0),
    .start_i     (line_start),
    .done_o      (line_done),
    .res_o       (line_res)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdib_pkg::ST_IDLE;
      cnt_q   <= '0;
      line_q  <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      line_q  <= line_d;
      pass_q  <= pass_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    line_d  = line_q;
    pass_d  = pass_q;
    case (state_q)
      rdib_pkg::ST_IDLE: begin
        if (run_fire) begin
          if (blk_end) begin
            state_d = rdib_pkg::ST_LD;
            cnt_d   = '0;
            line_d  = '0;
            pass_d  = 1'b0;
          end else begin
            state_d = rdib_pkg::ST_MUL1;
          end
        end
      end
      rdib_pkg::ST_MUL1: state_d = dc_q ? rdib_pkg::ST_WR : rdib_pkg::ST_MUL2;
      rdib_pkg::ST_MUL2: state_d = rdib_pkg::ST_WR;
      rdib_pkg::ST_WR:   state_d = rdib_pkg::ST_IDLE;
      rdib_pkg::ST_LD: begin
        if (cnt_q[3]) begin
          state_d = rdib_pkg::ST_START;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      rdib_pkg::ST_START: state_d = rdib_pkg::ST_CALC;
      rdib_pkg::ST_CALC: begin
        if (line_done) begin
          state_d = pass_q ? rdib_pkg::ST_OUT : rdib_pkg::ST_ST;
          cnt_d   = '0;
        end
      end
      rdib_pkg::ST_ST: begin
        if (cnt_q[2:0] == 3'd7) begin
          cnt_d   = '0;
          state_d = rdib_pkg::ST_LD;
          line_d  = line_q + 3'd1;
          if (line_q == 3'd7) begin
            pass_d = 1'b1;
          end
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      rdib_pkg::ST_OUT: begin
        if (out_fire) begin
          if (cnt_q[2:0] == 3'd7) begin
            cnt_d  = '0;
            line_d = line_q + 3'd1;
            state_d = (line_q == 3'd7) ? rdib_pkg::ST_IDLE : rdib_pkg::ST_LD;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
      end
      default: state_d = rdib_pkg::ST_IDLE;
    endcase
  end

  // block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q       <= '0;
      pos_q       <= '0;
      scale_q     <= '0;
      expect_dc_q <= 1'b1;
      dc_q        <= 1'b0;
    end else begin
      if (run_fire) begin
        dc_q <= expect_dc_q;
        if (expect_dc_q) begin
          scale_q     <= word_value_i[15:10];
          pos_q       <= '0;
          expect_dc_q <= 1'b0;
        end else if (!blk_end) begin
          pos_q <= new_pos[5:0];
        end
      end
      if (out_fire && last_out) begin
        expect_dc_q <= 1'b1;
        pos_q       <= '0;
        blk_q       <= (blk_q == 3'(BLOCKS_PER_MB - 1)) ? 3'd0 : blk_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_fire) begin
      val_q <= word_value_i[9:0];
    end
    case (state_q)
      rdib_pkg::ST_MUL1: prod_q <= 32'({7'd0, q_rdata_q}) * sx_val;
      rdib_pkg::ST_MUL2: prod_q <= prod_q * {26'd0, scale_q};
      default: begin
      end
    endcase
  end

  assign block_number_o    = blk_q;
  assign pixel_position_o  = {line_q, cnt_q[2:0]};
  assign sample_out_o      = line_res[cnt_q[2:0]];
  assign block_last_o      = last_out;
  assign macroblock_last_o = last_out && (blk_q == 3'(BLOCKS_PER_MB - 1));

endmodule

// File: hdl/rdib_checker.sv
// rdib_checker: port-level assertions for the block decoder, bound to the top level
// depends on rdib_pkg and rle_dequant_idct_block_decoder_core
module rdib_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  block_number_o,
  input logic [5:0]  pixel_position_o,
  input logic [31:0] sample_out_o,
  input logic        block_last_o,
  input logic        macroblock_last_o
);

  // stalled output transfer holds its sample and pixel position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(sample_out_o) && $stable(pixel_position_o))
    else $error("output payload changed while stalled");

  // no input while samples are leaving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken during sample output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && block_last_o |-> pixel_position_o == 6'd63)
    else $error("block_last away from last position");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && macroblock_last_o |->
      block_last_o && block_number_o == 3'(rdib_pkg::BLOCKS_PER_MB - 1))
    else $error("macroblock_last on wrong sample");

endmodule

bind rle_dequant_idct_block_decoder_core rdib_checker u_rdib_checker (.*);

// File: test/rdib_checker.sv
// rdib_tb_checker: watches both channels of the block decoder, predicts samples and compares them
// depends on rdib_pkg for tables, request codes and idct constants
`timescale 1ns / 1ps

module rdib_tb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  req_type_i,
  input  logic [5:0]  table_index_i,
  input  logic [15:0] word_value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  block_number_i,
  input  logic [5:0]  pixel_position_i,
  input  logic [31:0] sample_out_i,
  input  logic        block_last_i,
  input  logic        macroblock_last_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [2:0]  blk;
    logic [5:0]  pos;
    logic [31:0] smp;
    logic        blast;
    logic        mblast;
  } sample_t;

  sample_t     sample_q[$];
  logic [31:0] coefs[64];
  logic [31:0] luma_q[64];
  logic [31:0] chroma_q[64];
  logic [2:0]  blk_cnt;
  logic [6:0]  zz_pos;
  logic [5:0]  ac_scale;
  logic        want_dc;

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx10(input logic [15:0] w);
    return {{22{w[9]}}, w[9:0]};
  endfunction

  task automatic idct8(input int base, input int stride);
    logic [31:0] a[8];
    logic [31:0] z5, z10, z11, z12, z13, t0, t1, t2, t3, t4, t5, t6, t7;
    for (int k = 0; k < 8; k++) a[k] = coefs[base + k * stride];
    z10 = a[0] + a[4];
    z11 = a[0] - a[4];
    z13 = a[2] + a[6];
    z12 = sra((a[2] - a[6]) * rdib_pkg::K_A4, 12) - z13;
    t0 = z10 + z13; t3 = z10 - z13; t1 = z11 + z12; t2 = z11 - z12;
    z13 = a[3] + a[5]; z10 = a[3] - a[5]; z11 = a[1] + a[7]; z12 = a[1] - a[7];
    t7 = z11 + z13;
    z5 = (z12 - z10) * rdib_pkg::K_A2;
    t6 = sra(z10 * rdib_pkg::K_B2 + z5, 12) - t7;
    t5 = sra((z11 - z13) * rdib_pkg::K_A4, 12) - t6;
    t4 = sra(z12 * rdib_pkg::K_B6 - z5, 12) + t5;
    coefs[base]              = t0 + t7;
    coefs[base + 7 * stride] = t0 - t7;
    coefs[base + stride]     = t1 + t6;
    coefs[base + 6 * stride] = t1 - t6;
    coefs[base + 2 * stride] = t2 + t5;
    coefs[base + 5 * stride] = t2 - t5;
    coefs[base + 4 * stride] = t3 + t4;
    coefs[base + 3 * stride] = t3 - t4;
  endtask

  task automatic close_block();
    sample_t s;
    for (int i = 0; i < 8; i++) idct8(i, 8);
    for (int i = 0; i < 8; i++) idct8(i * 8, 1);
    for (int i = 0; i < 64; i++) begin
      s.blk = blk_cnt;
      s.pos = 6'(i);
      s.smp = coefs[i];
      s.blast = (i == 63);
      s.mblast = (i == 63) && (blk_cnt == 3'(rdib_pkg::BLOCKS_PER_MB - 1));
      sample_q.push_back(s);
      coefs[i] = '0;
    end
    want_dc = 1'b1;
    zz_pos = '0;
    blk_cnt = (blk_cnt == 3'(rdib_pkg::BLOCKS_PER_MB - 1)) ? 3'd0 : blk_cnt + 3'd1;
  endtask

  task automatic decode_word(input logic [1:0] rt, input logic [5:0] idx,
                             input logic [15:0] w);
    logic [31:0] pre, v, qv;
    if (rt == rdib_pkg::REQ_LUMA || rt == rdib_pkg::REQ_CHROMA) begin
      pre = (32'(rdib_pkg::PRESCALE_NAT[rdib_pkg::ZZ_TO_NAT[idx]]) + 32'd8) >> 4;
      v = (32'(w[7:0]) * pre) & 32'h1FF_FFFF;
      if (rt == rdib_pkg::REQ_LUMA) luma_q[idx] = v;
      else chroma_q[idx] = v;
    end else if (rt == rdib_pkg::REQ_RUN) begin
      if (want_dc) begin
        qv = (blk_cnt < 2) ? chroma_q[0] : luma_q[0];
        ac_scale = w[15:10];
        coefs[0] = sra(qv * sx10(w) + 32'd256, 9);
        zz_pos = '0;
        want_dc = 1'b0;
      end else if (w == rdib_pkg::END_CODE) begin
        close_block();
      end else begin
        zz_pos = zz_pos + 7'(w[15:10]) + 7'd1;
        if (zz_pos > 63) close_block();
        else begin
          qv = (blk_cnt < 2) ? chroma_q[zz_pos[5:0]] : luma_q[zz_pos[5:0]];
          coefs[rdib_pkg::ZZ_TO_NAT[zz_pos[5:0]]] =
            sra(sx10(w) * qv * 32'(ac_scale) + 32'd2048, 12);
        end
      end
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
    $display("mismatch %s: got %0h expected %0h", what, got, exp_v);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    for (int i = 0; i < 64; i++) begin
      coefs[i] = '0; luma_q[i] = '0; chroma_q[i] = '0;
    end
    blk_cnt = '0; zz_pos = '0; ac_scale = '0; want_dc = 1'b1;
  end

  always @(posedge clk_i) begin
    sample_t e;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (sample_q.size() == 0) begin
          report("unexpected sample", sample_out_i, '0);
        end else begin
          e = sample_q.pop_front();
          if (block_number_i !== e.blk)
            report("block_number", 32'(block_number_i), 32'(e.blk));
          if (pixel_position_i !== e.pos)
            report("pixel_position", 32'(pixel_position_i), 32'(e.pos));
          if (sample_out_i !== e.smp) report("sample_out", sample_out_i, e.smp);
          if (block_last_i !== e.blast) report("block_last", 32'(block_last_i), 32'(e.blast));
          if (macroblock_last_i !== e.mblast)
            report("macroblock_last", 32'(macroblock_last_i), 32'(e.mblast));
        end
      end
      if (in_valid_i && in_ready_i) decode_word(req_type_i, table_index_i, word_value_i);
    end
    pending_o = sample_q.size();
  end
endmodule

// File: test/rle_dequant_idct_block_decoder_core_tb.sv
// rle_dequant_idct_block_decoder_core_tb: stimulus, clock, reset and verdict for the block decoder
// depends on rdib_pkg, rdib_tb_checker and rle_dequant_idct_block_decoder_core
`timescale 1ns / 1ps

module rle_dequant_idct_block_decoder_core_tb;

  localparam int STALL_LIMIT = 20000;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [1:0]  req_type_i;
  logic [5:0]  table_index_i;
  logic [15:0] word_value_i;
  logic [2:0]  block_number_o;
  logic [5:0]  pixel_position_o;
  logic [31:0] sample_out_o;
  logic        block_last_o, macroblock_last_o;
  int          fail_count, pending, idle_cycles;
  logic        out_stall_on;

  rle_dequant_idct_block_decoder_core DUT (.*);

  rdib_tb_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .table_index_i,
    .word_value_i, .out_valid_i(out_valid_o), .out_ready_i, .block_number_i(block_number_o),
    .pixel_position_i(pixel_position_o), .sample_out_i(sample_out_o),
    .block_last_i(block_last_o), .macroblock_last_i(macroblock_last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // send one item, after a random input gap while stalls are on, and wait for its transfer
  task automatic send(input logic [1:0] rt, input logic [5:0] idx, input logic [15:0] w);
    int g;
    g = out_stall_on ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rt;
    table_index_i <= idx;
    word_value_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic idle_in();
    in_valid_i <= 1'b0;
  endtask

  task automatic load_tables(input bit full_range);
    for (int i = 0; i < 64; i++) begin
      send(rdib_pkg::REQ_LUMA, 6'(i),
           full_range ? 16'($urandom) : 16'($urandom_range(1, 16)));
      send(rdib_pkg::REQ_CHROMA, 6'(i),
           full_range ? 16'($urandom) : 16'($urandom_range(1, 16)));
    end
  endtask

  // one block of random run-level content, with quant or ignored requests mixed in
  task automatic random_block();
    int n;
    n = $urandom_range(0, 6);
    send(rdib_pkg::REQ_RUN, 6'($urandom), 16'($urandom));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0)
        send(2'($urandom_range(1, 3)), 6'($urandom), 16'($urandom));
      else
        send(rdib_pkg::REQ_RUN, 6'($urandom), {6'($urandom_range(0, 8)), 10'($urandom)});
    end
    if ($urandom_range(0, 3) == 0) send(rdib_pkg::REQ_RUN, '0, {6'd63, 10'($urandom)});
    else send(rdib_pkg::REQ_RUN, '0, rdib_pkg::END_CODE);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = rdib_pkg::REQ_RUN;
    table_index_i = '0;
    word_value_i = '0;
    out_stall_on = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    load_tables(1'b1);
    // end code taken as dc, then end
    send(rdib_pkg::REQ_RUN, '0, rdib_pkg::END_CODE);
    send(rdib_pkg::REQ_RUN, '0, rdib_pkg::END_CODE);
    // extreme dc and ac values, runs past the zigzag end, mid-block table writes and an ignored request
    send(rdib_pkg::REQ_RUN, 6'h3F, 16'hFDFF);
    send(rdib_pkg::REQ_RUN, '0, 16'h0200);
    send(rdib_pkg::REQ_RUN, '0, 16'h01FF);
    send(rdib_pkg::REQ_LUMA, 6'd3, 16'hFFFF);
    send(rdib_pkg::REQ_CHROMA, 6'd3, 16'h00FF);
    send(2'd3, 6'h3F, 16'hFFFF);
    send(rdib_pkg::REQ_RUN, '0, {6'd61, 10'h155});
    send(rdib_pkg::REQ_RUN, '0, {6'd0, 10'h2AA});
    send(rdib_pkg::REQ_RUN, '0, {6'd63, 10'h3FF});
    for (int b = 0; b < 4; b++) begin
      send(rdib_pkg::REQ_RUN, '0, 16'h03FF);
      send(rdib_pkg::REQ_RUN, '0, rdib_pkg::END_CODE);
    end
    out_stall_on = 1'b1;
    for (int b = 0; b < 10; b++) begin
      if (b == 5) load_tables(1'b0);
      random_block();
    end
    for (int k = 0; k < 8; k++) send(2'($urandom_range(1, 3)), 6'($urandom), 16'($urandom));
    idle_in();
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0)
      $display("** rle_dequant_idct_block_decoder_core: PASSED **");
    else
      $display("** rle_dequant_idct_block_decoder_core: FAILED **");
    $finish;
  end

  // output stalls, with stretches of none
  initial begin
    int g;
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (out_stall_on && $urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_ready_i <= 1'b0;
          repeat (g) @(negedge clk_i);
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** rle_dequant_idct_block_decoder_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end
endmodule

// File: files.f
hdl/rdib_pkg.sv
hdl/rdib_idct_line.sv
hdl/rle_dequant_idct_block_decoder_core.sv
hdl/rdib_checker.sv
test/rdib_checker.sv
test/rle_dequant_idct_block_decoder_core_tb.sv
